@@ rtl/vcdg_pkg.sv @@
// ----------------------------------------------------------------------------
// vcdg_pkg
// shared constants, register codes and item flags of the volume gradient block
// ----------------------------------------------------------------------------
package vcdg_pkg;

  localparam int MAX_ROW_DEF     = 256;
  localparam int MAX_ROWS_DEF    = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_DIM_BITS    = 9;
  localparam int CFG_DEPTH_BITS  = 16;
  localparam int CFG_ADDR_BITS   = 2;
  localparam int CFG_DATA_BITS   = 16;

  localparam int DIM_RESET       = 256;
  localparam int DEPTH_RESET     = 256;

  localparam int QUEUE_DEPTH     = 4;

  localparam logic [CFG_ADDR_BITS-1:0] REG_VOL_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_VOL_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_VOL_DEPTH  = 2'd2;

  typedef struct packed {
    logic is_interior;
    logic is_last;
    logic vol_end;
    logic x_one;
  } vcdg_flags_t;

endpackage

@@ rtl/volume_central_difference_gradient.sv @@
// ----------------------------------------------------------------------------
// volume_central_difference_gradient
// streaming 3-d central-difference gradient with running interior minimum
// ----------------------------------------------------------------------------
// Takes one sample beat per clock, while the result queue has room, in
// x-fastest raster order and gives one result beat for each interior voxel,
// a plane after the voxel itself. The sustained rate of one beat per cycle
// is set by the window stores: two copies of a two-plane memory, each of
// 2 * MAX_ROW * MAX_ROWS words with both sizes rounded up to powers of two,
// every copy written once and read at two addresses per beat. The stores
// are not cleared after reset; only results from the third plane onward
// use them. Any write to a size register restarts the volume and the minimum.
// ----------------------------------------------------------------------------
module volume_central_difference_gradient #(
  parameter int MAX_ROW     = vcdg_pkg::MAX_ROW_DEF,
  parameter int MAX_ROWS    = vcdg_pkg::MAX_ROWS_DEF,
  parameter int SAMPLE_BITS = vcdg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]           in_tdata,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // grad_x, grad_y, grad_z, centre_value, running_min
  output logic [((5*SAMPLE_BITS+3+7)/8)*8-1:0]       out_tdata,
  output logic                                       out_tlast,
  input  logic                                       cfg_we,
  input  logic [vcdg_pkg::CFG_ADDR_BITS-1:0]         cfg_addr,
  input  logic [vcdg_pkg::CFG_DATA_BITS-1:0]         cfg_wdata
);

  import vcdg_pkg::*;

  localparam int OUT_W   = ((5 * SAMPLE_BITS + 3 + 7) / 8) * 8;
  localparam int FIELD_W = 5 * SAMPLE_BITS + 3;
  localparam int TAP_W   = 5 * SAMPLE_BITS;
  localparam int Q_W     = $bits(vcdg_flags_t) + TAP_W;

  logic                                  restart;
  logic                                  push_valid;
  vcdg_flags_t                           push_flags, q_flags;
  logic [TAP_W-1:0]                      push_taps, q_taps;
  logic [Q_W-1:0]                        q_data;
  logic                                  q_valid, q_pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0]      q_level;
  logic signed [SAMPLE_BITS:0]           grad_x, grad_y, grad_z;
  logic signed [SAMPLE_BITS-1:0]         centre_value, running_min;
  logic [FIELD_W-1:0]                    fields;

  vcdg_front #(
    .MAX_ROW     (MAX_ROW),
    .MAX_ROWS    (MAX_ROWS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_sample  (in_tdata[SAMPLE_BITS-1:0]),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_level    (q_level),
    .restart    (restart),
    .push_valid (push_valid),
    .push_flags (push_flags),
    .push_taps  (push_taps)
  );

  vcdg_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data ({push_flags, push_taps}),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid),
    .level     (q_level)
  );

  assign q_flags = q_data[Q_W-1 -: $bits(vcdg_flags_t)];
  assign q_taps  = q_data[TAP_W-1:0];

  vcdg_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .restart       (restart),
    .q_valid       (q_valid),
    .q_flags       (q_flags),
    .q_taps        (q_taps),
    .q_pop         (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .grad_x        (grad_x),
    .grad_y        (grad_y),
    .grad_z        (grad_z),
    .centre_value  (centre_value),
    .running_min   (running_min),
    .last_interior (out_tlast)
  );

  assign fields    = {running_min, centre_value, grad_z, grad_y, grad_x};
  assign out_tdata = OUT_W'(fields);

endmodule

@@ rtl/vcdg_ram.sv @@
// ----------------------------------------------------------------------------
// vcdg_ram
// generic memory, one write port and two registered read ports, read-first
// ----------------------------------------------------------------------------
module vcdg_ram #(
  parameter int WIDTH = vcdg_pkg::SAMPLE_BITS_DEF,
  parameter int DEPTH = 2 * vcdg_pkg::MAX_ROW_DEF * vcdg_pkg::MAX_ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

@@ rtl/vcdg_front.sv @@
// ----------------------------------------------------------------------------
// vcdg_front
// raster counters, voxel classification and the two-plane window stores
// ----------------------------------------------------------------------------
module vcdg_front #(
  parameter int MAX_ROW     = vcdg_pkg::MAX_ROW_DEF,
  parameter int MAX_ROWS    = vcdg_pkg::MAX_ROWS_DEF,
  parameter int SAMPLE_BITS = vcdg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [SAMPLE_BITS-1:0]                    in_sample,
  input  logic                                      cfg_we,
  input  logic [vcdg_pkg::CFG_ADDR_BITS-1:0]        cfg_addr,
  input  logic [vcdg_pkg::CFG_DATA_BITS-1:0]        cfg_wdata,
  input  logic [$clog2(vcdg_pkg::QUEUE_DEPTH+1)-1:0] q_level,
  output logic                                      restart,
  output logic                                      push_valid,
  output vcdg_pkg::vcdg_flags_t                     push_flags,
  output logic [5*SAMPLE_BITS-1:0]                  push_taps
);

  import vcdg_pkg::*;

  localparam int XW        = $clog2(MAX_ROW);
  localparam int YW        = $clog2(MAX_ROWS);
  localparam int AW        = 1 + YW + XW;
  localparam int RAM_DEPTH = 2 ** AW;
  localparam int WW        = $clog2(MAX_ROW + 1);
  localparam int HW        = $clog2(MAX_ROWS + 1);
  localparam int DW1       = (WW > HW) ? WW : HW;
  localparam int DW        = ((DW1 > CFG_DIM_BITS) ? DW1 : CFG_DIM_BITS) + 1;
  localparam int ZW        = CFG_DEPTH_BITS + 1;
  localparam int LW        = $clog2(QUEUE_DEPTH + 1) + 1;

  logic [CFG_DIM_BITS-1:0]   vol_width_r, vol_height_r;
  logic [CFG_DEPTH_BITS-1:0] vol_depth_r;
  logic [XW-1:0]             x_r, x_nxt;
  logic [YW-1:0]             y_r, y_nxt;
  logic [CFG_DEPTH_BITS-1:0] z_r, z_nxt;
  logic                      s1_valid_r;
  vcdg_flags_t               s1_flags_r, flags_nxt;
  logic [SAMPLE_BITS-1:0]    s1_sample_r;

  logic [DW-1:0]             w_ext, h_ext, w_eff, h_eff, x_ext, y_ext;
  logic [CFG_DEPTH_BITS-1:0] d_eff;
  logic [ZW-1:0]             z_ext, d_ext;
  logic                      accept, row_end, plane_end, vol_last, size_ok;
  logic                      pc, pp;
  logic [AW-1:0]             a_raddr_a, a_raddr_b, b_raddr_a, b_raddr_b, waddr;
  logic [SAMPLE_BITS-1:0]    a_rdata_a, a_rdata_b, b_rdata_a, b_rdata_b;

  // effective volume size
  always_comb begin
    w_ext = DW'(vol_width_r);
    h_ext = DW'(vol_height_r);
    if (w_ext == '0) begin
      w_eff = DW'(1);
    end else if (w_ext > DW'(MAX_ROW)) begin
      w_eff = DW'(MAX_ROW);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = DW'(1);
    end else if (h_ext > DW'(MAX_ROWS)) begin
      h_eff = DW'(MAX_ROWS);
    end else begin
      h_eff = h_ext;
    end
    d_eff = (vol_depth_r == '0) ? CFG_DEPTH_BITS'(1) : vol_depth_r;
  end

  assign x_ext = DW'(x_r);
  assign y_ext = DW'(y_r);
  assign z_ext = ZW'(z_r);
  assign d_ext = ZW'(d_eff);

  assign row_end   = (x_ext + DW'(1)) >= w_eff;
  assign plane_end = (y_ext + DW'(1)) >= h_eff;
  assign vol_last  = (z_ext + ZW'(1)) >= d_ext;
  assign size_ok   = (w_eff >= DW'(3)) && (h_eff >= DW'(3)) && (d_eff >= CFG_DEPTH_BITS'(3));

  // classification of the voxel one plane back
  always_comb begin
    flags_nxt.is_interior = size_ok && (x_r != '0) && ((x_ext + DW'(1)) < w_eff) &&
                            (y_r != '0) && ((y_ext + DW'(1)) < h_eff) &&
                            (z_r >= CFG_DEPTH_BITS'(2));
    flags_nxt.is_last     = ((x_ext + DW'(2)) == w_eff) && ((y_ext + DW'(2)) == h_eff) &&
                            ((z_ext + ZW'(1)) == d_ext);
    flags_nxt.vol_end     = row_end && plane_end && vol_last;
    flags_nxt.x_one       = (x_r == XW'(1));
  end

  assign in_ready = ({1'b0, q_level} + LW'(s1_valid_r)) < LW'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;
  assign restart  = cfg_we && ((cfg_addr == REG_VOL_WIDTH) || (cfg_addr == REG_VOL_HEIGHT) ||
                               (cfg_addr == REG_VOL_DEPTH));

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (restart) begin
      x_nxt = '0;
      y_nxt = '0;
      z_nxt = '0;
    end else if (accept) begin
      if (row_end) begin
        x_nxt = '0;
        if (plane_end) begin
          y_nxt = '0;
          z_nxt = vol_last ? '0 : z_r + CFG_DEPTH_BITS'(1);
        end else begin
          y_nxt = y_r + YW'(1);
        end
      end else begin
        x_nxt = x_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_width_r  <= CFG_DIM_BITS'(DIM_RESET);
      vol_height_r <= CFG_DIM_BITS'(DIM_RESET);
      vol_depth_r  <= CFG_DEPTH_BITS'(DEPTH_RESET);
      x_r          <= '0;
      y_r          <= '0;
      z_r          <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_VOL_WIDTH:  vol_width_r  <= cfg_wdata[CFG_DIM_BITS-1:0];
          REG_VOL_HEIGHT: vol_height_r <= cfg_wdata[CFG_DIM_BITS-1:0];
          REG_VOL_DEPTH:  vol_depth_r  <= cfg_wdata[CFG_DEPTH_BITS-1:0];
          default: ;
        endcase
      end
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      z_r        <= z_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags_r  <= flags_nxt;
      s1_sample_r <= in_sample;
    end
  end

  // pc holds plane z-1, pp still holds plane z-2 until this beat overwrites it
  assign pc    = ~z_r[0];
  assign pp    = z_r[0];
  assign waddr = {pp, y_r, x_r};

  // store a: row above (or column zero of this row on the first beat of a row), row below
  assign a_raddr_a = (x_r == '0) ? {pc, y_r, XW'(0)} : {pc, y_r - YW'(1), x_r};
  assign a_raddr_b = {pc, y_r + YW'(1), x_r};
  // store b: right neighbour in this row, same voxel two planes back
  assign b_raddr_a = {pc, y_r, x_r + XW'(1)};
  assign b_raddr_b = {pp, y_r, x_r};

  vcdg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_store_a (
    .clk     (clk),
    .we      (accept),
    .waddr   (waddr),
    .wdata   (in_sample),
    .raddr_a (a_raddr_a),
    .raddr_b (a_raddr_b),
    .rdata_a (a_rdata_a),
    .rdata_b (a_rdata_b)
  );

  vcdg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_store_b (
    .clk     (clk),
    .we      (accept),
    .waddr   (waddr),
    .wdata   (in_sample),
    .raddr_a (b_raddr_a),
    .raddr_b (b_raddr_b),
    .rdata_a (b_rdata_a),
    .rdata_b (b_rdata_b)
  );

  assign push_valid = s1_valid_r;
  assign push_flags = s1_flags_r;
  assign push_taps  = {s1_sample_r, b_rdata_b, b_rdata_a, a_rdata_b, a_rdata_a};

endmodule

@@ rtl/vcdg_fifo.sv @@
// ----------------------------------------------------------------------------
// vcdg_fifo
// short register queue between the front and the back
// ----------------------------------------------------------------------------
module vcdg_fifo #(
  parameter int WIDTH = 4 + 5 * vcdg_pkg::SAMPLE_BITS_DEF,
  parameter int DEPTH = vcdg_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data  = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign level     = count_r;

endmodule

@@ rtl/vcdg_back.sv @@
// ----------------------------------------------------------------------------
// vcdg_back
// gradient differences, running minimum and the result register
// ----------------------------------------------------------------------------
module vcdg_back #(
  parameter int SAMPLE_BITS = vcdg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          restart,
  input  logic                          q_valid,
  input  vcdg_pkg::vcdg_flags_t         q_flags,
  input  logic [5*SAMPLE_BITS-1:0]      q_taps,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS:0]   grad_x,
  output logic signed [SAMPLE_BITS:0]   grad_y,
  output logic signed [SAMPLE_BITS:0]   grad_z,
  output logic signed [SAMPLE_BITS-1:0] centre_value,
  output logic signed [SAMPLE_BITS-1:0] running_min,
  output logic                          last_interior
);

  import vcdg_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic signed [SAMPLE_BITS-1:0] up_or_col0, down, right, back2, smp;
  logic signed [SAMPLE_BITS-1:0] prev_a0_r, prev_b0_r, prev2_b0_r;
  logic signed [SAMPLE_BITS-1:0] left, centre, min_cand;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic signed [SAMPLE_BITS:0]   gx, gy, gz;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS:0]   grad_x_r, grad_y_r, grad_z_r;
  logic signed [SAMPLE_BITS-1:0] centre_r, run_min_r;
  logic                          last_r;

  assign up_or_col0 = q_taps[0*SAMPLE_BITS +: SAMPLE_BITS];
  assign down       = q_taps[1*SAMPLE_BITS +: SAMPLE_BITS];
  assign right      = q_taps[2*SAMPLE_BITS +: SAMPLE_BITS];
  assign back2      = q_taps[3*SAMPLE_BITS +: SAMPLE_BITS];
  assign smp        = q_taps[4*SAMPLE_BITS +: SAMPLE_BITS];

  // centre and left come from the right-neighbour reads of earlier beats; left at x one comes from the column-zero read
  assign centre   = prev_b0_r;
  assign left     = q_flags.x_one ? prev_a0_r : prev2_b0_r;
  assign gx       = (SAMPLE_BITS + 1)'(left) - (SAMPLE_BITS + 1)'(right);
  assign gy       = (SAMPLE_BITS + 1)'(up_or_col0) - (SAMPLE_BITS + 1)'(down);
  assign gz       = (SAMPLE_BITS + 1)'(back2) - (SAMPLE_BITS + 1)'(smp);
  assign min_cand = (centre < min_r) ? centre : min_r;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    min_nxt       = min_r;
    out_valid_nxt = out_valid_r;
    if (restart) begin
      min_nxt = SMAX;
    end else if (q_pop) begin
      if (q_flags.vol_end) begin
        min_nxt = SMAX;
      end else if (q_flags.is_interior) begin
        min_nxt = min_cand;
      end
    end
    if (q_pop && q_flags.is_interior) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= SMAX;
      out_valid_r <= 1'b0;
    end else begin
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prev_a0_r  <= up_or_col0;
      prev_b0_r  <= right;
      prev2_b0_r <= prev_b0_r;
      if (q_flags.is_interior) begin
        grad_x_r  <= gx;
        grad_y_r  <= gy;
        grad_z_r  <= gz;
        centre_r  <= centre;
        run_min_r <= min_cand;
        last_r    <= q_flags.is_last;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign grad_x        = grad_x_r;
  assign grad_y        = grad_y_r;
  assign grad_z        = grad_z_r;
  assign centre_value  = centre_r;
  assign running_min   = run_min_r;
  assign last_interior = last_r;

endmodule

@@ rtl/vcdg_checker.sv @@
// ----------------------------------------------------------------------------
// vcdg_checker
// port-level checks of the volume gradient block, bound to the top level
// ----------------------------------------------------------------------------
module vcdg_checker #(
  parameter int SAMPLE_BITS = vcdg_pkg::SAMPLE_BITS_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((5*SAMPLE_BITS+3+7)/8)*8-1:0] out_tdata,
  input logic                                 out_tlast
);

  localparam int CTR_LO = 3 * (SAMPLE_BITS + 1);
  localparam int MIN_LO = CTR_LO + SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] ctr_f, min_f;
  logic                          out_beat;

  assign ctr_f    = out_tdata[CTR_LO +: SAMPLE_BITS];
  assign min_f    = out_tdata[MIN_LO +: SAMPLE_BITS];
  assign out_beat = out_tvalid && out_tready;

  // reset empties the result side
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // the minimum includes the voxel itself
  a_min_le_ctr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> min_f <= ctr_f)
    else $error("running minimum above centre value");

  // a new volume needs whole planes before its first result
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && out_tlast |=> !out_beat)
    else $error("result right after final interior voxel");

endmodule

bind volume_central_difference_gradient vcdg_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (.*);

@@ tb/volume_central_difference_gradient_tb.sv @@
// ----------------------------------------------------------------------------
// volume_central_difference_gradient_tb
// self-checking bench for the streaming 3-d central-difference gradient
// ----------------------------------------------------------------------------
// A short stimulus table first sends a few beats at the reset sizes. It then
// builds one 3x3x3 volume whose single interior voxel has full-scale x and y
// neighbours, and that result is written out by hand. Random phases follow.
// Each phase programs new volume sizes while the block is idle: saturated
// widths and heights, empty volumes, depth zero and the deepest volume are
// among them. It then streams random samples, at times stopping partway
// through a volume. Every accepted sample goes through a local model of the
// two-plane window. Result beats are checked in order against it, under four
// patterns of source gaps and sink stalls.
// ----------------------------------------------------------------------------
module volume_central_difference_gradient_tb;
  import vcdg_pkg::*;

  localparam int MAXW     = MAX_ROW_DEF;
  localparam int MAXH     = MAX_ROWS_DEF;
  localparam int IN_W     = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam int OUT_W    = ((5 * SAMPLE_BITS_DEF + 3 + 7) / 8) * 8;
  localparam int LIMIT    = 400000;
  localparam int SETTLE   = 8;
  localparam int N_PHASES = 16;
  localparam int N_DIR    = 19;
  localparam int N_SAT    = 64;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [16:0] gx;
    logic signed [16:0] gy;
    logic signed [16:0] gz;
    logic signed [15:0] centre;
    logic signed [15:0] rmin;
    logic               last;
  } grad_beat_t;

  typedef enum logic {ROW_CFG, ROW_BEATS} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_ADDR_BITS-1:0] idx;
    logic [15:0]              count;
    logic [15:0]              value;
    logic                     fixed;
    grad_beat_t               res;
  } dir_row_t;

  localparam grad_beat_t NO_RES = '0;
  localparam grad_beat_t CORNER_RES = '{gx: 17'sd65535, gy: -17'sd65535, gz: -17'sd1,
                                        centre: 16'h8000, rmin: 16'h8000, last: 1'b1};

  // 3x3x3 volume: x-1 = max, x+1 = min, y-1 = min, y+1 = max, z-1 = -1, centre min
  dir_row_t dir_tab [N_DIR] = '{
    '{ROW_BEATS, REG_VOL_WIDTH,  16'd1, 16'h8000, 1'b0, NO_RES},
    '{ROW_BEATS, REG_VOL_WIDTH,  16'd1, 16'h7fff, 1'b0, NO_RES},
    '{ROW_CFG,   REG_VOL_WIDTH,  16'd0, 16'd3,    1'b0, NO_RES},
    '{ROW_CFG,   REG_VOL_HEIGHT, 16'd0, 16'd3,    1'b0, NO_RES},
    '{ROW_CFG,   REG_VOL_DEPTH,  16'd0, 16'd3,    1'b0, NO_RES},
    '{ROW_CFG,   REG_SPARE,      16'd0, 16'hffff, 1'b0, NO_RES},
    '{ROW_BEATS, REG_VOL_WIDTH,  16'd4, 16'h0000, 1'b0, NO_RES},
    '{ROW_BEATS, REG_VOL_WIDTH,  16'd1, 16'hffff, 1'b0, NO_RES},
    '{ROW_BEATS, REG_VOL_WIDTH,  16'd5, 16'h0000, 1'b0, NO_RES},
    '{ROW_BEATS, REG_VOL_WIDTH,  16'd1, 16'h8000, 1'b0, NO_RES},
    '{ROW_BEATS, REG_VOL_WIDTH,  16'd1, 16'h0000, 1'b0, NO_RES},
    '{ROW_BEATS, REG_VOL_WIDTH,  16'd1, 16'h7fff, 1'b0, NO_RES},
    '{ROW_BEATS, REG_VOL_WIDTH,  16'd1, 16'h8000, 1'b0, NO_RES},
    '{ROW_BEATS, REG_VOL_WIDTH,  16'd1, 16'h8000, 1'b0, NO_RES},
    '{ROW_BEATS, REG_VOL_WIDTH,  16'd1, 16'h0000, 1'b0, NO_RES},
    '{ROW_BEATS, REG_VOL_WIDTH,  16'd1, 16'h7fff, 1'b0, NO_RES},
    '{ROW_BEATS, REG_VOL_WIDTH,  16'd5, 16'h0000, 1'b0, NO_RES},
    '{ROW_BEATS, REG_VOL_WIDTH,  16'd1, 16'h0000, 1'b1, CORNER_RES},
    '{ROW_BEATS, REG_VOL_WIDTH,  16'd4, 16'h0000, 1'b0, NO_RES}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_W-1:0]          in_tdata;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_W-1:0]         out_tdata;
  logic                     out_tlast;
  logic                     cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  volume_central_difference_gradient DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // window model state
  logic signed [15:0] win_mem [2*MAXW*MAXH];
  logic [8:0]         reg_w;
  logic [8:0]         reg_h;
  logic [15:0]        reg_d;
  int                 col_n;
  int                 row_n;
  int                 plane_n;
  logic signed [15:0] vol_min;

  grad_beat_t pending_grads [$];
  int         src_gap_pct;
  int         rcv_stall_pct;
  int         beats_sent;
  int         grads_seen;
  int         errors;
  int         cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int win_addr(int par, int y, int x);
    return ((par % 2) * MAXH + y) * MAXW + x;
  endfunction

  function automatic logic [16:0] diff17(logic signed [15:0] a, logic signed [15:0] b);
    int t;
    t = a - b;
    return t[16:0];
  endfunction

  function automatic void restart_volume();
    col_n   = 0;
    row_n   = 0;
    plane_n = 0;
    vol_min = 16'sh7fff;
  endfunction

  function automatic bit predict_gradient(logic signed [15:0] s, output grad_beat_t r);
    int w, h, d, rw, rh;
    bit hit;
    rw  = reg_w;
    rh  = reg_h;
    w   = (rw < 1) ? 1 : (rw > MAXW) ? MAXW : rw;
    h   = (rh < 1) ? 1 : (rh > MAXH) ? MAXH : rh;
    d   = (reg_d == 0) ? 1 : int'(reg_d);
    r   = '0;
    hit = w >= 3 && h >= 3 && d >= 3 && col_n >= 1 && col_n + 1 < w &&
          row_n >= 1 && row_n + 1 < h && plane_n >= 2;
    if (hit) begin
      r.centre = win_mem[win_addr(plane_n - 1, row_n, col_n)];
      r.gx     = diff17(win_mem[win_addr(plane_n - 1, row_n, col_n - 1)],
                        win_mem[win_addr(plane_n - 1, row_n, col_n + 1)]);
      r.gy     = diff17(win_mem[win_addr(plane_n - 1, row_n - 1, col_n)],
                        win_mem[win_addr(plane_n - 1, row_n + 1, col_n)]);
      r.gz     = diff17(win_mem[win_addr(plane_n, row_n, col_n)], s);
      if (r.centre < vol_min) vol_min = r.centre;
      r.rmin   = vol_min;
      r.last   = (col_n + 2 == w) && (row_n + 2 == h) && (plane_n + 1 == d);
    end
    win_mem[win_addr(plane_n, row_n, col_n)] = s;
    col_n++;
    if (col_n >= w) begin
      col_n = 0;
      row_n++;
      if (row_n >= h) begin
        row_n = 0;
        plane_n++;
        if (plane_n >= d) begin
          plane_n = 0;
          vol_min = 16'sh7fff;
        end
      end
    end
    return hit;
  endfunction

  function automatic logic [15:0] pick_voxel();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [15:0] s, input bit fixed, input grad_beat_t fixed_res);
    grad_beat_t r;
    bit hit;
    @(negedge clk);
    while ($urandom_range(99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    hit = predict_gradient($signed(s), r);
    if (hit || fixed) pending_grads.push_back(fixed ? fixed_res : r);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_VOL_WIDTH: begin
        reg_w = val[8:0];
        restart_volume();
      end
      REG_VOL_HEIGHT: begin
        reg_h = val[8:0];
        restart_volume();
      end
      REG_VOL_DEPTH: begin
        reg_d = val;
        restart_volume();
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(99) >= rcv_stall_pct);

  always @(posedge clk) begin : result_check
    grad_beat_t got;
    grad_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[16:0], out_tdata[33:17], out_tdata[50:34],
             out_tdata[66:51], out_tdata[82:67], out_tlast};
      grads_seen++;
      if (pending_grads.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat %0d: gx %0d gy %0d gz %0d c %0d min %0d last %0b",
                   grads_seen, got.gx, got.gy, got.gz, got.centre, got.rmin, got.last);
      end else begin
        want = pending_grads.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("result beat %0d mismatch", grads_seen);
            $display("  got      gx %0d gy %0d gz %0d c %0d min %0d last %0b",
                     got.gx, got.gy, got.gz, got.centre, got.rmin, got.last);
            $display("  expected gx %0d gy %0d gz %0d c %0d min %0d last %0b",
                     want.gx, want.gy, want.gz, want.centre, want.rmin, want.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_grads.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int w, h, d, n, vol, ew, eh, ed, rot, k;
    logic [CFG_ADDR_BITS-1:0] regs [3];
    logic [15:0] vals [3];
    regs          = '{REG_VOL_WIDTH, REG_VOL_HEIGHT, REG_VOL_DEPTH};
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    src_gap_pct   = 0;
    rcv_stall_pct = 0;
    beats_sent    = 0;
    grads_seen    = 0;
    errors        = 0;
    cycles        = 0;
    reg_w         = 9'(DIM_RESET);
    reg_h         = 9'(DIM_RESET);
    reg_d         = 16'(DEPTH_RESET);
    restart_volume();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(dir_tab[i].idx, dir_tab[i].value);
      end else begin
        for (int j = 0; j < dir_tab[i].count; j++)
          send_sample(dir_tab[i].value, dir_tab[i].fixed, dir_tab[i].res);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      case (p % 4)
        0: begin src_gap_pct = 0;  rcv_stall_pct = 0;  end
        1: begin src_gap_pct = 78; rcv_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  rcv_stall_pct = 78; end
        default: begin src_gap_pct = 19; rcv_stall_pct = 19; end
      endcase
      case (p)
        2:  begin w = 511; h = 3;   d = 3;     end
        5:  begin w = 3;   h = 400; d = 3;     end
        11: begin w = 5;   h = 4;   d = 65535; end
        12: begin w = 4;   h = 4;   d = 0;     end
        default: begin
          w = ($urandom_range(9) == 0) ? $urandom_range(2) : 3 + $urandom_range(3);
          h = ($urandom_range(9) == 0) ? $urandom_range(2) : 3 + $urandom_range(2);
          d = ($urandom_range(7) == 0) ? $urandom_range(2) : 3 + $urandom_range(1);
        end
      endcase
      vals[0] = 16'(w);
      vals[1] = 16'(h);
      vals[2] = 16'(d);
      rot     = $urandom_range(2);
      for (int j = 0; j < 3; j++) write_reg(regs[(rot + j) % 3], vals[(rot + j) % 3]);
      ew  = (w < 1) ? 1 : (w > MAXW) ? MAXW : w;
      eh  = (h < 1) ? 1 : (h > MAXH) ? MAXH : h;
      ed  = (d < 1) ? 1 : d;
      vol = ew * eh * ((ed > 6) ? 6 : ed);
      if (p == 2 || p == 5) n = N_SAT;
      else if (ew < 3 || eh < 3 || ed < 3) n = 30;
      else n = (vol * 3) / 4 + $urandom_range(vol / 2);
      for (k = 0; k < n; k++) begin
        // unused register index must not disturb the volume in flight
        if (k == n / 2 && $urandom_range(2) == 0) begin
          drain_results();
          write_reg(REG_SPARE, 16'($urandom));
        end
        send_sample(pick_voxel(), 1'b0, NO_RES);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("%0d sample beats in %0d random phases plus the directed table", beats_sent,
             N_PHASES);
    $display("%0d gradient result beats checked, %0d mismatches", grads_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/vcdg_pkg.sv
rtl/vcdg_ram.sv
rtl/vcdg_front.sv
rtl/vcdg_fifo.sv
rtl/vcdg_back.sv
rtl/volume_central_difference_gradient.sv
rtl/vcdg_checker.sv
tb/volume_central_difference_gradient_tb.sv
